FILE: hw/rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// shared types, codes and sizes of the session lease table
// ----------------------------------------------------------------------------
package slt_pkg;

   // table size and derived index widths
   localparam int unsigned TABLE_ENTRIES = 16;
   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

   // action codes
   localparam logic [1:0] ACT_REQUEST = 2'd0;
   localparam logic [1:0] ACT_DELETE  = 2'd1;
   localparam logic [1:0] ACT_LOOKUP  = 2'd2;
   localparam logic [1:0] ACT_SWEEP   = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_REPLY   = 2'd0;
   localparam logic [1:0] KIND_DELETED = 2'd1;
   localparam logic [1:0] KIND_RENEWED = 2'd2;

   // status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_FAIL      = 3'd1;
   localparam logic [2:0] STAT_NOT_EXIST = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_ALT_FAIL  = 3'd4;
   localparam logic [2:0] STAT_ALT_LIMIT = 3'd5;

   typedef struct packed {
      logic [1:0]         action;
      logic [31:0]        session_id;
      logic signed [31:0] period;
      logic               ygsap_proto;
      logic [31:0]        now;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  status;
      logic [31:0] result_id;
      logic [32:0] expire_time;
      logic        found;
      logic        valid_res;
      logic        alt_session;
      logic        last;
   } rsp_type;

   // one stored session
   typedef struct packed {
      logic [31:0] id;
      logic [32:0] expiry;
      logic        alt;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   // sequencer to output stage
   typedef struct packed {
      logic    load;
      rsp_type data;
   } emit_type;

   // sequencer to table memory
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } ram_ctl_type;

endpackage

FILE: hw/rtl/slt_ram.sv
// ----------------------------------------------------------------------------
// slt_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module slt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/slt_out.sv
// ----------------------------------------------------------------------------
// slt_out
// result register between the sequencer and the rsp channel
// ----------------------------------------------------------------------------
module slt_out (
   input  logic              clock,
   input  logic              reset,
   input  slt_pkg::emit_type emit,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slt_pkg::rsp_type  rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   slt_pkg::rsp_type data_ff;

   // free when empty or when the held transaction leaves this edge
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (emit.load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (emit.load) begin
         data_ff <= emit.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: hw/rtl/slt_seq.sv
// ----------------------------------------------------------------------------
// slt_seq
// request sequencer: table scan, notices, replies and write-back
// ----------------------------------------------------------------------------
module slt_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  slt_pkg::req_type     req_data,
   input  logic                 out_free,
   output slt_pkg::emit_type    emit,
   output slt_pkg::ram_ctl_type ram_ctl,
   input  slt_pkg::entry_type   rd_ent
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_NOTE  = 4'b0100,
      S_REPLY = 4'b1000
   } seq_state_type;

   seq_state_type                      state_ff, state_in;
   slt_pkg::req_type                   req_ff, req_in;
   logic [slt_pkg::CNT_W-1:0]          addr_ff, addr_in;
   logic [slt_pkg::IDX_W-1:0]          chk_ff, chk_in;
   logic                               chk_vld_ff, chk_vld_in;
   logic                               hit_ff, hit_in;
   logic [slt_pkg::IDX_W-1:0]          slot_ff, slot_in;
   slt_pkg::entry_type                 ent_ff, ent_in;
   logic [slt_pkg::TABLE_ENTRIES-1:0]  live_ff, live_in;
   logic [31:0]                        next_id_ff, next_id_in;

   logic        is_create;
   logic        is_sweep;
   logic        p_zero;
   logic        p_neg;
   logic [32:0] now_x;
   logic [32:0] new_exp;
   logic        chk_live;
   logic        sel_hit;
   logic        sweep_drop;
   logic        hold;
   logic        chk_last;
   logic        del_note;
   logic        renew_ok;
   logic        create_ok;
   logic [31:0] id_inc;
   slt_pkg::rsp_type notice;
   slt_pkg::rsp_type reply;

   assign is_create = (req_ff.action == slt_pkg::ACT_REQUEST) && (req_ff.session_id == '0);
   assign is_sweep  = (req_ff.action == slt_pkg::ACT_SWEEP);
   assign p_zero    = (req_ff.period == '0);
   assign p_neg     = req_ff.period[31];
   assign now_x     = {1'b0, req_ff.now};
   assign new_exp   = now_x + {1'b0, req_ff.period};

   // entry under check: not live reads as a free, zero entry
   assign chk_live   = live_ff[chk_ff];
   assign sel_hit    = chk_vld_ff && !is_sweep &&
                       (is_create ? !chk_live : (chk_live && rd_ent.id == req_ff.session_id));
   assign sweep_drop = chk_vld_ff && is_sweep && chk_live &&
                       (rd_ent.expiry != '0) && (rd_ent.expiry < now_x);
   assign hold       = sweep_drop && !out_free;
   assign chk_last   = (chk_ff == slt_pkg::IDX_W'(slt_pkg::TABLE_ENTRIES - 1));

   assign del_note  = hit_ff && !is_create &&
                      ((req_ff.action == slt_pkg::ACT_REQUEST && p_zero) ||
                       req_ff.action == slt_pkg::ACT_DELETE);
   assign renew_ok  = hit_ff && !is_create && (req_ff.action == slt_pkg::ACT_REQUEST) &&
                      !p_zero && !p_neg && (ent_ff.expiry != '0);
   assign create_ok = is_create && !p_zero && hit_ff;

   assign id_inc = next_id_ff + 32'd1;

   // notice for the note state (renew or delete of the matched slot)
   always_comb begin
      notice             = '0;
      notice.result_id   = ent_ff.id;
      if (renew_ok) begin
         notice.kind        = slt_pkg::KIND_RENEWED;
         notice.expire_time = new_exp;
      end else begin
         notice.kind        = slt_pkg::KIND_DELETED;
         notice.expire_time = ent_ff.expiry;
      end
   end

   // final reply of the transaction
   always_comb begin
      reply           = '0;
      reply.kind      = slt_pkg::KIND_REPLY;
      reply.last      = 1'b1;
      reply.result_id = req_ff.session_id;
      unique case (req_ff.action)
         slt_pkg::ACT_REQUEST: begin
            if (is_create) begin
               if (p_zero) begin
                  reply.status = req_ff.ygsap_proto ? slt_pkg::STAT_ALT_FAIL : slt_pkg::STAT_FAIL;
               end else if (!hit_ff) begin
                  reply.status = req_ff.ygsap_proto ? slt_pkg::STAT_ALT_LIMIT : slt_pkg::STAT_FULL;
               end else begin
                  reply.status      = slt_pkg::STAT_OK;
                  reply.result_id   = next_id_ff;
                  reply.expire_time = p_neg ? '0 : new_exp;
               end
               if (!create_ok) begin
                  reply.result_id = '0;
               end
            end else if (!hit_ff) begin
               reply.status = req_ff.ygsap_proto ? slt_pkg::STAT_ALT_FAIL : slt_pkg::STAT_NOT_EXIST;
            end else if (p_zero) begin
               reply.status = slt_pkg::STAT_OK;
            end else if (renew_ok) begin
               reply.status      = slt_pkg::STAT_OK;
               reply.expire_time = new_exp;
            end else begin
               reply.status = req_ff.ygsap_proto ? slt_pkg::STAT_ALT_FAIL : slt_pkg::STAT_FAIL;
            end
         end
         slt_pkg::ACT_DELETE: begin
            reply.status = hit_ff ? slt_pkg::STAT_OK : slt_pkg::STAT_NOT_EXIST;
         end
         slt_pkg::ACT_LOOKUP: begin
            if (hit_ff) begin
               reply.status      = slt_pkg::STAT_OK;
               reply.expire_time = ent_ff.expiry;
               reply.found       = 1'b1;
               reply.valid_res   = (ent_ff.expiry == '0) || (ent_ff.expiry > now_x);
               reply.alt_session = ent_ff.alt;
            end else begin
               reply.status      = slt_pkg::STAT_NOT_EXIST;
               reply.expire_time = 33'd1;
            end
         end
         slt_pkg::ACT_SWEEP: begin
            reply.status    = slt_pkg::STAT_OK;
            reply.result_id = '0;
         end
         default: begin
            reply.status = slt_pkg::STAT_OK;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      addr_in    = addr_ff;
      chk_in     = chk_ff;
      chk_vld_in = chk_vld_ff;
      hit_in     = hit_ff;
      slot_in    = slot_ff;
      ent_in     = ent_ff;
      live_in    = live_ff;
      next_id_in = next_id_ff;
      emit       = '0;
      ram_ctl         = '0;
      ram_ctl.rd_addr = addr_ff[slt_pkg::IDX_W-1:0];
      ram_ctl.wr_addr = slot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               addr_in    = '0;
               chk_vld_in = 1'b0;
               hit_in     = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sweep_drop && out_free) begin
               emit.load             = 1'b1;
               emit.data             = '0;
               emit.data.kind        = slt_pkg::KIND_DELETED;
               emit.data.result_id   = rd_ent.id;
               emit.data.expire_time = rd_ent.expiry;
               live_in[chk_ff]       = 1'b0;
            end
            if (sel_hit) begin
               hit_in     = 1'b1;
               slot_in    = chk_ff;
               ent_in     = rd_ent;
               chk_vld_in = 1'b0;
               state_in   = S_NOTE;
            end else if (chk_vld_ff && chk_last && !hold) begin
               chk_vld_in = 1'b0;
               state_in   = S_NOTE;
            end else if (!hold) begin
               if (addr_ff < slt_pkg::CNT_W'(slt_pkg::TABLE_ENTRIES)) begin
                  ram_ctl.rd_en = 1'b1;
                  addr_in       = addr_ff + 1'b1;
                  chk_in        = addr_ff[slt_pkg::IDX_W-1:0];
                  chk_vld_in    = 1'b1;
               end else begin
                  chk_vld_in = 1'b0;
               end
            end
         end
         S_NOTE: begin
            if (del_note || renew_ok) begin
               if (out_free) begin
                  emit.load = 1'b1;
                  emit.data = notice;
                  if (renew_ok) begin
                     ram_ctl.wr_en   = 1'b1;
                     ram_ctl.wr_data = '{id: ent_ff.id, expiry: new_exp, alt: ent_ff.alt};
                  end else begin
                     live_in[slot_ff] = 1'b0;
                  end
                  state_in = S_REPLY;
               end
            end else begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               emit.load = 1'b1;
               emit.data = reply;
               if (create_ok) begin
                  ram_ctl.wr_en    = 1'b1;
                  ram_ctl.wr_data  = '{id: next_id_ff,
                                       expiry: (p_neg ? 33'd0 : new_exp),
                                       alt: req_ff.ygsap_proto};
                  live_in[slot_ff] = 1'b1;
                  next_id_in       = (id_inc == '0) ? 32'd1 : id_inc;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         chk_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         live_ff    <= '0;
         next_id_ff <= 32'd1;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         hit_ff     <= hit_in;
         live_ff    <= live_in;
         next_id_ff <= next_id_in;
      end
      req_ff  <= req_in;
      addr_ff <= addr_in;
      chk_ff  <= chk_in;
      slot_ff <= slot_in;
      ent_ff  <= ent_in;
   end

   assign req_stall = (state_ff != S_IDLE);

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_SCAN))
      else $error("accepted transaction did not start a table scan");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (emit.load && emit.data.last) |=> (state_ff == S_IDLE))
      else $error("final reply did not return the sequencer to idle");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      emit.load |-> out_free)
      else $error("result loaded into a stalled output register");

   a_no_read_write: assert property (@(posedge clock) disable iff (reset)
      !(ram_ctl.rd_en && ram_ctl.wr_en))
      else $error("table read and write-back in the same cycle");

   a_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_id_ff != '0)
      else $error("session id counter reached zero");

endmodule

FILE: hw/rtl/session_lease_table.sv
// ----------------------------------------------------------------------------
// session_lease_table
// fixed table of leased sessions with create, renew, delete, lookup and sweep
// ----------------------------------------------------------------------------
// Each req transaction runs one pass over the session table. The table sits in
// one memory with a registered read port, and the scan reads one entry per
// cycle unless a sweep notice is held by a stalled output register. When the
// scan runs to the end (a sweep, a miss or a full table) the reply is placed
// in the output register from the reply state, after the note state. A lookup,
// renew, delete or create stops the scan at its first matching slot and goes
// on to the same note and reply states. The next req transaction is taken in
// the cycle after the reply is placed. Notices need no state of their own:
// a delete or renew notice from a request or a delete by id goes out in the
// note state that every transaction passes through anyway, and sweep notices
// go out during the scan itself. Only a cycle in which the rsp side stalls a
// pending result while the sequencer has another one to place holds the
// sequencer. One transaction is worked on at a time: req_stall stays high
// from acceptance until the final reply (last = 1) has been placed in the
// output register. Reset clears the per-slot live bits and sets the id
// counter to 1; there is no clearing pass, and req transactions are taken
// as soon as reset is released.
// ----------------------------------------------------------------------------
module session_lease_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  slt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output slt_pkg::rsp_type rsp_data
);

   slt_pkg::emit_type    emit;
   slt_pkg::ram_ctl_type ram_ctl;
   slt_pkg::entry_type   rd_ent;
   logic                 out_free;
   logic [slt_pkg::ENTRY_W-1:0] rd_word;

   // session store: id, expiry and protocol flag per slot
   slt_ram #(
      .WIDTH (slt_pkg::ENTRY_W),
      .DEPTH (slt_pkg::TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (ram_ctl.wr_data),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (rd_word)
   );

   assign rd_ent = slt_pkg::entry_type'(rd_word);

   // scan, decision and write-back; write-back only after the scan has
   // stopped, so no read of the same slot is ever in flight
   slt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .emit      (emit),
      .ram_ctl   (ram_ctl),
      .rd_ent    (rd_ent)
   );

   // output register, frees the sequencer from the rsp side's stall
   slt_out u_out (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
